// File: hw/rtl/afl_pkg.sv
// Shared types and constants for the advisory file lock table.
// Used by every module under hw/rtl except afl_ram; depends on nothing.
package afl_pkg;

    localparam int IDX_W  = 6;
    localparam int OPB_W  = 4;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    localparam int DESCRIPTOR_COUNT_DEF = 64;
    localparam int FILE_COUNT_DEF       = 64;

    // operation bits that take part in decoding (nonblocking is masked off)
    localparam logic [OPB_W-1:0] OP_DECODE_MASK = 4'b1011;
    localparam logic [OPB_W-1:0] OP_SHARED      = 4'b0001;
    localparam logic [OPB_W-1:0] OP_EXCLUSIVE   = 4'b0010;
    localparam logic [OPB_W-1:0] OP_UNLOCK      = 4'b1000;
    localparam int               OP_NB_BIT      = 2;

    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE = 2'd0,
        MODE_SH   = 2'd1,
        MODE_EX   = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_WOULD_BLOCK = 2'd2,
        ST_MUST_WAIT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CLS_RANGE,
        CLS_INVALID,
        CLS_NOP,
        CLS_DROP,
        CLS_SHARED,
        CLS_EXCL
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic             nb;
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] f;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic multi;
    } t_qstat;

    typedef enum logic [1:0] {
        XS_IDLE,
        XS_READ,
        XS_EXEC
    } t_xstate;

endpackage

// File: hw/rtl/afl_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module afl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/afl_front.sv
// Front stage: accepts a request, range-checks and decodes it into a command.
// Depends on afl_pkg.
module afl_front #(
    parameter int DESCRIPTOR_COUNT = afl_pkg::DESCRIPTOR_COUNT_DEF,
    parameter int FILE_COUNT       = afl_pkg::FILE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_kind,
    input  logic [afl_pkg::IDX_W-1:0]   i_descriptor_index,
    input  logic [afl_pkg::IDX_W-1:0]   i_file_index,
    input  logic                        i_file_present,
    input  logic [afl_pkg::OPB_W-1:0]   i_operation_bits,
    input  afl_pkg::t_qstat             i_qstat,
    output logic                        o_busy,
    output logic                        o_push,
    output afl_pkg::t_cmd               o_cmd
);

    logic                      r_valid, n_valid;
    afl_pkg::t_cmd             r_cmd, n_cmd;
    afl_pkg::t_cmd             cls_cmd;
    logic [afl_pkg::OPB_W-1:0] op;
    logic                      range_ok;
    logic                      accept;

    assign o_busy = r_valid && i_qstat.full;
    assign o_push = r_valid && !i_qstat.full;
    assign o_cmd  = r_cmd;
    assign accept = i_start && !o_busy;

    always_comb begin
        op       = i_operation_bits & afl_pkg::OP_DECODE_MASK;
        range_ok = (32'(i_descriptor_index) < DESCRIPTOR_COUNT)
                && (32'(i_file_index) < FILE_COUNT);
        cls_cmd.d  = i_descriptor_index;
        cls_cmd.f  = i_file_index;
        cls_cmd.nb = i_operation_bits[afl_pkg::OP_NB_BIT];
        if (!range_ok) begin
            cls_cmd.cls = afl_pkg::CLS_RANGE;
        end else if (i_kind == afl_pkg::KIND_CLOSE) begin
            cls_cmd.cls = i_file_present ? afl_pkg::CLS_DROP : afl_pkg::CLS_NOP;
        end else if (!(op inside {afl_pkg::OP_SHARED, afl_pkg::OP_EXCLUSIVE,
                                  afl_pkg::OP_UNLOCK})) begin
            cls_cmd.cls = afl_pkg::CLS_INVALID;
        end else if (!i_file_present) begin
            cls_cmd.cls = afl_pkg::CLS_INVALID;
        end else if (op == afl_pkg::OP_UNLOCK) begin
            cls_cmd.cls = afl_pkg::CLS_DROP;
        end else if (op == afl_pkg::OP_EXCLUSIVE) begin
            cls_cmd.cls = afl_pkg::CLS_EXCL;
        end else begin
            cls_cmd.cls = afl_pkg::CLS_SHARED;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid = 1'b1;
            n_cmd   = cls_cmd;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// File: hw/rtl/afl_queue.sv
// Two-entry command queue between the front and the execute stage.
// Depends on afl_pkg.
module afl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  afl_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output afl_pkg::t_cmd   o_head,
    output afl_pkg::t_qstat o_stat
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    afl_pkg::t_cmd r_buf [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_head       = r_buf[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.multi = (r_count > CW'(1));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");
`endif

endmodule

// File: hw/rtl/afl_exec.sv
// Execute stage: reads descriptor and file entries, applies the lock rules,
// writes back and registers the result. Depends on afl_pkg and afl_ram.
module afl_exec #(
    parameter int DESCRIPTOR_COUNT = afl_pkg::DESCRIPTOR_COUNT_DEF,
    parameter int FILE_COUNT       = afl_pkg::FILE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afl_pkg::t_cmd                i_head,
    input  afl_pkg::t_qstat              i_qstat,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [afl_pkg::STAT_W-1:0]   o_status,
    output logic                         o_waiters_wake,
    output logic [afl_pkg::MODE_W-1:0]   o_held_mode
);

    localparam int IDX_SPAN = 1 << afl_pkg::IDX_W;
    localparam int DDEPTH = (DESCRIPTOR_COUNT < IDX_SPAN) ? DESCRIPTOR_COUNT : IDX_SPAN;
    localparam int FDEPTH = (FILE_COUNT < IDX_SPAN) ? FILE_COUNT : IDX_SPAN;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int CW     = $clog2(DESCRIPTOR_COUNT + 1);
    localparam int FW     = 1 + afl_pkg::IDX_W + CW;

    afl_pkg::t_xstate r_state, n_state;

    logic [DDEPTH-1:0] r_dv;
    logic [FDEPTH-1:0] r_fv;

    logic [DAW-1:0]                    daddr;
    logic [FAW-1:0]                    faddr;
    logic                              d_we, f_we;
    logic [afl_pkg::MODE_W-1:0]        d_rdata, d_wdata;
    logic [FW-1:0]                     f_rdata, f_wdata;

    logic [afl_pkg::MODE_W-1:0]        m, want, new_m, held;
    logic                              ev, new_ev;
    logic [afl_pkg::IDX_W-1:0]         eh, new_eh;
    logic [CW-1:0]                     sc, new_sc, own_sh;
    logic                              drop_now, grant, free, wake;
    afl_pkg::t_status                  status;

    logic                              r_strobe;
    logic [afl_pkg::STAT_W-1:0]        r_status;
    logic                              r_wake;
    logic [afl_pkg::MODE_W-1:0]        r_held;

    assign daddr = i_head.d[DAW-1:0];
    assign faddr = i_head.f[FAW-1:0];

    afl_ram #(.WIDTH(afl_pkg::MODE_W), .DEPTH(DDEPTH), .AW(DAW)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_addr  (daddr),
        .i_wdata (d_wdata),
        .o_rdata (d_rdata)
    );

    afl_ram #(.WIDTH(FW), .DEPTH(FDEPTH), .AW(FAW)) u_file_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_addr  (faddr),
        .i_wdata (f_wdata),
        .o_rdata (f_rdata)
    );

    // lock rules on the entries read for the queue head
    always_comb begin
        m = r_dv[daddr] ? d_rdata : afl_pkg::MODE_NONE;
        if (r_fv[faddr]) begin
            {ev, eh, sc} = f_rdata;
        end else begin
            {ev, eh, sc} = '0;
        end
        want     = (i_head.cls == afl_pkg::CLS_EXCL) ? afl_pkg::MODE_EX : afl_pkg::MODE_SH;
        own_sh   = (m == afl_pkg::MODE_SH) ? CW'(1) : CW'(0);
        free     = !(ev && (eh != i_head.d))
                && !((want == afl_pkg::MODE_EX) && (sc > own_sh));
        drop_now = 1'b0;
        grant    = 1'b0;
        wake     = 1'b0;
        status   = afl_pkg::ST_OK;
        new_m    = m;
        new_ev   = ev;
        new_eh   = eh;
        new_sc   = sc;

        case (i_head.cls)
            afl_pkg::CLS_RANGE, afl_pkg::CLS_INVALID: begin
                status = afl_pkg::ST_INVALID;
            end
            afl_pkg::CLS_DROP: begin
                if (m != afl_pkg::MODE_NONE) begin
                    drop_now = 1'b1;
                    wake     = 1'b1;
                end
            end
            afl_pkg::CLS_SHARED, afl_pkg::CLS_EXCL: begin
                if (m != want) begin
                    if (free) begin
                        grant    = 1'b1;
                        drop_now = (m != afl_pkg::MODE_NONE);
                        wake     = (m == afl_pkg::MODE_EX);
                    end else begin
                        status = i_head.nb ? afl_pkg::ST_WOULD_BLOCK
                                           : afl_pkg::ST_MUST_WAIT;
                    end
                end
            end
            default: begin
            end
        endcase

        if (drop_now) begin
            if (m == afl_pkg::MODE_EX && ev && (eh == i_head.d)) begin
                new_ev = 1'b0;
            end else if (m == afl_pkg::MODE_SH && sc != '0) begin
                new_sc = sc - CW'(1);
            end
            new_m = afl_pkg::MODE_NONE;
        end
        if (grant) begin
            if (want == afl_pkg::MODE_EX) begin
                new_ev = 1'b1;
                new_eh = i_head.d;
            end else if (32'(new_sc) < DESCRIPTOR_COUNT) begin
                new_sc = new_sc + CW'(1);
            end
            new_m = want;
        end

        held    = (i_head.cls == afl_pkg::CLS_RANGE) ? afl_pkg::MODE_NONE : new_m;
        d_wdata = new_m;
        f_wdata = {new_ev, new_eh, new_sc};
    end

    // read, then execute and write back
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        d_we    = 1'b0;
        f_we    = 1'b0;
        case (r_state)
            afl_pkg::XS_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = afl_pkg::XS_READ;
                end
            end
            afl_pkg::XS_READ: begin
                n_state = afl_pkg::XS_EXEC;
            end
            afl_pkg::XS_EXEC: begin
                o_pop   = 1'b1;
                d_we    = (i_head.cls != afl_pkg::CLS_RANGE);
                f_we    = (i_head.cls != afl_pkg::CLS_RANGE);
                n_state = i_qstat.multi ? afl_pkg::XS_READ : afl_pkg::XS_IDLE;
            end
            default: begin
                n_state = afl_pkg::XS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= afl_pkg::XS_IDLE;
            r_strobe <= 1'b0;
            r_dv     <= '0;
            r_fv     <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == afl_pkg::XS_EXEC);
            if (d_we) begin
                r_dv[daddr] <= 1'b1;
            end
            if (f_we) begin
                r_fv[faddr] <= 1'b1;
            end
        end
        if (r_state == afl_pkg::XS_EXEC) begin
            r_status <= status;
            r_wake   <= wake;
            r_held   <= held;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_waiters_wake = r_wake;
    assign o_held_mode    = r_held;

`ifndef NO_ASSERTIONS
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) == afl_pkg::XS_EXEC)
        else $error("result strobe without an execute cycle");
    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == afl_pkg::XS_EXEC && i_head.cls == afl_pkg::CLS_RANGE) |=>
        (r_status == afl_pkg::ST_INVALID && r_held == afl_pkg::MODE_NONE && !r_wake))
        else $error("out-of-range request produced a non-invalid result");
`endif

endmodule

// File: hw/rtl/advisory_file_lock_table.sv
// Advisory file lock table: shared/exclusive locks per descriptor and file.
// Path: front register, two-entry queue, RAM read state, execute and write-back
// state, result register. The front and queue accept requests while one executes.
// busy rises only when the front register and the two-entry queue are full.
// Reset (synchronous, active low) empties the pipeline and marks all table
// entries unwritten, so they read as zero at once; results cannot be stalled.
module advisory_file_lock_table #(
    parameter int DESCRIPTOR_COUNT = afl_pkg::DESCRIPTOR_COUNT_DEF,
    parameter int FILE_COUNT       = afl_pkg::FILE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [afl_pkg::IDX_W-1:0]    i_descriptor_index,
    input  logic [afl_pkg::IDX_W-1:0]    i_file_index,
    input  logic                         i_file_present,
    input  logic [afl_pkg::OPB_W-1:0]    i_operation_bits,
    output logic                         o_strobe,
    output logic [afl_pkg::STAT_W-1:0]   o_status,
    output logic                         o_waiters_wake,
    output logic [afl_pkg::MODE_W-1:0]   o_held_mode
);

    logic            push, pop;
    afl_pkg::t_cmd   front_cmd, head_cmd;
    afl_pkg::t_qstat qstat;

    afl_front #(
        .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
        .FILE_COUNT       (FILE_COUNT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_kind             (i_kind),
        .i_descriptor_index (i_descriptor_index),
        .i_file_index       (i_file_index),
        .i_file_present     (i_file_present),
        .i_operation_bits   (i_operation_bits),
        .i_qstat            (qstat),
        .o_busy             (busy),
        .o_push             (push),
        .o_cmd              (front_cmd)
    );

    afl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (qstat)
    );

    afl_exec #(
        .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
        .FILE_COUNT       (FILE_COUNT)
    ) u_exec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_waiters_wake (o_waiters_wake),
        .o_held_mode    (o_held_mode)
    );

endmodule

// File: sim/tb.sv
// Testbench for advisory_file_lock_table: directed table, random lock traffic, then a shared-count leak run.
// Directed rows are checked against their listed replies, other items against a lock table kept in the testbench.
// Depends on afl_pkg and the advisory_file_lock_table RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afl_pkg::*;

    localparam int DESC_N    = DESCRIPTOR_COUNT_DEF;
    localparam int FILE_N    = FILE_COUNT_DEF;
    localparam int NUM_DIR   = 24;
    localparam int NUM_RAND  = 600;
    localparam int NUM_LEAK  = 70;
    localparam int HOT_DESCS = 12;
    localparam int LEAK_FILE = 40;

    localparam logic             KIND_LOCK = ~KIND_CLOSE;
    localparam logic [OPB_W-1:0] OP_NB     = 4'(1 << OP_NB_BIT);
    localparam logic [OPB_W-1:0] OP_NONE   = '0;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] desc;
        logic [IDX_W-1:0] file;
        logic             present;
        logic [OPB_W-1:0] ops;
    } t_req;

    typedef struct packed {
        t_status status;
        logic    wake;
        t_mode   held;
    } t_resp;

    typedef struct packed {
        t_req  req;
        logic  typed;
        t_resp want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_kind;
    logic [IDX_W-1:0] i_descriptor_index;
    logic [IDX_W-1:0] i_file_index;
    logic             i_file_present;
    logic [OPB_W-1:0] i_operation_bits;
    logic             o_strobe;
    logic [STAT_W-1:0] o_status;
    logic             o_waiters_wake;
    logic [MODE_W-1:0] o_held_mode;

    // lock table as the testbench sees it
    t_mode      desc_mode  [DESC_N];
    logic       excl_valid [FILE_N];
    logic [5:0] excl_owner [FILE_N];
    logic [6:0] sh_holders [FILE_N];

    logic [IDX_W-1:0] home_file [DESC_N];
    t_resp lock_replies_due[$];
    t_row  dir_tab [NUM_DIR];
    int    err_count = 0;
    bit    idling_on = 1'b1;

    advisory_file_lock_table i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_kind             (i_kind),
        .i_descriptor_index (i_descriptor_index),
        .i_file_index       (i_file_index),
        .i_file_present     (i_file_present),
        .i_operation_bits   (i_operation_bits),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_waiters_wake     (o_waiters_wake),
        .o_held_mode        (o_held_mode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void release_lock(logic [5:0] d, logic [5:0] f);
        if (desc_mode[d] == MODE_EX && excl_valid[f] && excl_owner[f] == d) begin
            excl_valid[f] = 1'b0;
        end else if (desc_mode[d] == MODE_SH) begin
            if (sh_holders[f] != 0) sh_holders[f] = 7'(sh_holders[f] - 1);
        end
        desc_mode[d] = MODE_NONE;
    endfunction

    function automatic t_resp apply_request(t_req r);
        t_resp            res;
        logic [OPB_W-1:0] op;
        t_mode            want;
        t_mode            had;
        int               own_sh;
        res.status = ST_OK;
        res.wake   = 1'b0;
        had        = desc_mode[r.desc];
        if (r.kind == KIND_CLOSE) begin
            if (had != MODE_NONE && r.present) begin
                release_lock(r.desc, r.file);
                res.wake = 1'b1;
            end
        end else begin
            op = r.ops & OP_DECODE_MASK;
            if (op != OP_SHARED && op != OP_EXCLUSIVE && op != OP_UNLOCK) begin
                res.status = ST_INVALID;
            end else if (!r.present) begin
                res.status = ST_INVALID;
            end else if (op == OP_UNLOCK) begin
                if (had != MODE_NONE) begin
                    release_lock(r.desc, r.file);
                    res.wake = 1'b1;
                end
            end else begin
                want   = (op == OP_EXCLUSIVE) ? MODE_EX : MODE_SH;
                own_sh = (had == MODE_SH) ? 1 : 0;
                if (had == want) begin
                    // already held in this mode
                end else if (!(excl_valid[r.file] && excl_owner[r.file] != r.desc) &&
                             !(want == MODE_EX && int'(sh_holders[r.file]) > own_sh)) begin
                    if (had != MODE_NONE) release_lock(r.desc, r.file);
                    if (want == MODE_EX) begin
                        excl_valid[r.file] = 1'b1;
                        excl_owner[r.file] = r.desc;
                    end else if (int'(sh_holders[r.file]) < DESC_N) begin
                        sh_holders[r.file] = 7'(sh_holders[r.file] + 1);
                    end
                    desc_mode[r.desc] = want;
                    if (had == MODE_EX) res.wake = 1'b1;
                end else begin
                    res.status = r.ops[OP_NB_BIT] ? ST_WOULD_BLOCK : ST_MUST_WAIT;
                end
            end
        end
        res.held = desc_mode[r.desc];
        return res;
    endfunction

    function automatic t_row row(logic kind, int d, int f, logic p, logic [OPB_W-1:0] ops,
                                 logic typed, t_status st, logic wk, t_mode hm);
        t_row x;
        x.req.kind    = kind;
        x.req.desc    = 6'(d);
        x.req.file    = 6'(f);
        x.req.present = p;
        x.req.ops     = ops;
        x.typed       = typed;
        x.want.status = st;
        x.want.wake   = wk;
        x.want.held   = hm;
        return x;
    endfunction

    function automatic t_row lock_row(int d, int f, logic [OPB_W-1:0] ops);
        return row(KIND_LOCK, d, f, 1'b1, ops, 1'b0, ST_OK, 1'b0, MODE_NONE);
    endfunction

    // mostly well-formed traffic on a few contended files, some noise
    function automatic t_row random_row();
        t_row x;
        int   roll;
        int   d;
        roll = int'($urandom_range(99));
        d    = ($urandom_range(9) < 8) ? int'($urandom_range(HOT_DESCS - 1))
                                       : int'($urandom_range(DESC_N - 1));
        x    = lock_row(d, int'(home_file[d]), OP_SHARED);
        if (roll < 88) begin
            x.req.kind = ($urandom_range(9) == 0) ? KIND_CLOSE : KIND_LOCK;
            case ($urandom_range(4))
                0, 1:    x.req.ops = OP_SHARED;
                2, 3:    x.req.ops = OP_EXCLUSIVE;
                default: x.req.ops = OP_UNLOCK;
            endcase
            if ($urandom_range(1)) x.req.ops = x.req.ops | OP_NB;
        end else begin
            x.req.kind    = 1'($urandom_range(1));
            x.req.file    = 6'($urandom_range(FILE_N - 1));
            x.req.present = 1'($urandom_range(1));
            x.req.ops     = 4'($urandom_range(15));
        end
        return x;
    endfunction

    function automatic int idle_cycles();
        int roll;
        roll = int'($urandom_range(99));
        if (!idling_on || roll < 40) return 0;
        if (roll < 85) return int'($urandom_range(3, 1));
        if (roll < 95) return int'($urandom_range(10, 4));
        return int'($urandom_range(60, 20));
    endfunction

    // hold start until the block takes the item, then predict its reply
    task automatic issue(t_row x);
        int    gap;
        t_resp res;
        gap = idle_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_kind             <= x.req.kind;
        i_descriptor_index <= x.req.desc;
        i_file_index       <= x.req.file;
        i_file_present     <= x.req.present;
        i_operation_bits   <= x.req.ops;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = apply_request(x.req);
        lock_replies_due.push_back(x.typed ? x.want : res);
    endtask

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_strobe) begin
            if (lock_replies_due.size() == 0) begin
                $error("reply with no request pending: status=%0d wake=%0d held_mode=%0d",
                       o_status, o_waiters_wake, o_held_mode);
                err_count++;
            end else begin
                exp_r = lock_replies_due.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    err_count++;
                end
                if (o_waiters_wake !== exp_r.wake) begin
                    $error("waiters_wake: expected %0d, got %0d", exp_r.wake, o_waiters_wake);
                    err_count++;
                end
                if (o_held_mode !== exp_r.held) begin
                    $error("held_mode: expected %0d, got %0d", exp_r.held, o_held_mode);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        start              <= 1'b0;
        i_kind             <= KIND_LOCK;
        i_descriptor_index <= '0;
        i_file_index       <= '0;
        i_file_present     <= 1'b0;
        i_operation_bits   <= OP_NONE;
        for (int i = 0; i < DESC_N; i++) begin
            desc_mode[i] = MODE_NONE;
            home_file[i] = ($urandom_range(3) == 0) ? 6'($urandom_range(FILE_N - 1))
                                                    : 6'($urandom_range(2));
        end
        for (int i = 0; i < FILE_N; i++) begin
            excl_valid[i] = 1'b0;
            excl_owner[i] = '0;
            sh_holders[i] = '0;
        end

        dir_tab = '{
            row(KIND_CLOSE, 0, 0, 1'b1, OP_NONE, 1'b1, ST_OK, 1'b0, MODE_NONE),
            row(KIND_LOCK, 0, 0, 1'b1, OP_NONE, 1'b1, ST_INVALID, 1'b0, MODE_NONE),
            row(KIND_LOCK, 0, 0, 1'b1, OP_SHARED | OP_EXCLUSIVE, 1'b1, ST_INVALID, 1'b0,
                MODE_NONE),
            row(KIND_LOCK, 1, 1, 1'b1, 4'hF, 1'b1, ST_INVALID, 1'b0, MODE_NONE),
            row(KIND_LOCK, 2, 2, 1'b0, OP_SHARED, 1'b1, ST_INVALID, 1'b0, MODE_NONE),
            row(KIND_LOCK, 63, 63, 1'b1, OP_EXCLUSIVE, 1'b1, ST_OK, 1'b0, MODE_EX),
            row(KIND_LOCK, 62, 63, 1'b1, OP_SHARED | OP_NB, 1'b1, ST_WOULD_BLOCK, 1'b0,
                MODE_NONE),
            row(KIND_LOCK, 62, 63, 1'b1, OP_SHARED, 1'b1, ST_MUST_WAIT, 1'b0, MODE_NONE),
            row(KIND_LOCK, 63, 63, 1'b1, OP_EXCLUSIVE, 1'b1, ST_OK, 1'b0, MODE_EX),
            // downgrade wakes waiters
            row(KIND_LOCK, 63, 63, 1'b1, OP_SHARED, 1'b1, ST_OK, 1'b1, MODE_SH),
            row(KIND_LOCK, 62, 63, 1'b1, OP_SHARED, 1'b1, ST_OK, 1'b0, MODE_SH),
            row(KIND_LOCK, 63, 63, 1'b1, OP_EXCLUSIVE | OP_NB, 1'b1, ST_WOULD_BLOCK, 1'b0,
                MODE_SH),
            row(KIND_LOCK, 62, 63, 1'b1, OP_UNLOCK, 1'b1, ST_OK, 1'b1, MODE_NONE),
            row(KIND_LOCK, 63, 63, 1'b1, OP_EXCLUSIVE, 1'b1, ST_OK, 1'b0, MODE_EX),
            row(KIND_CLOSE, 63, 63, 1'b0, OP_NONE, 1'b1, ST_OK, 1'b0, MODE_EX),
            row(KIND_CLOSE, 63, 63, 1'b1, 4'hF, 1'b1, ST_OK, 1'b1, MODE_NONE),
            row(KIND_LOCK, 5, 0, 1'b1, OP_UNLOCK, 1'b1, ST_OK, 1'b0, MODE_NONE),
            row(KIND_LOCK, 5, 0, 1'b1, OP_UNLOCK | OP_NB, 1'b1, ST_OK, 1'b0, MODE_NONE),
            // descriptor moved to another file: counters must not wrap
            lock_row(7, 10, OP_SHARED),
            lock_row(7, 11, OP_UNLOCK),
            lock_row(8, 20, OP_EXCLUSIVE),
            lock_row(8, 21, OP_SHARED),
            lock_row(9, 20, OP_SHARED | OP_NB),
            row(KIND_LOCK, 3, 21, 1'b0, OP_UNLOCK | OP_SHARED, 1'b1, ST_INVALID, 1'b0,
                MODE_NONE)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) issue(dir_tab[i]);

        for (int n = 0; n < NUM_RAND; n++) begin
            if (n % 50 == 0) idling_on = ($urandom_range(9) < 7);
            issue(random_row());
        end

        // take shared on one file and unlock through another, so the shared
        // count on the first climbs to its ceiling
        idling_on = 1'b1;
        for (int n = 0; n < NUM_LEAK; n++) begin
            issue(lock_row(n % DESC_N, LEAK_FILE, OP_SHARED));
            issue(lock_row(n % DESC_N, LEAK_FILE + 1, OP_UNLOCK));
        end
        issue(lock_row(0, LEAK_FILE, OP_EXCLUSIVE | OP_NB));
        issue(lock_row(1, LEAK_FILE, OP_SHARED));
        start <= 1'b0;

        while (lock_replies_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/afl_pkg.sv
hw/rtl/afl_ram.sv
hw/rtl/afl_front.sv
hw/rtl/afl_queue.sv
hw/rtl/afl_exec.sv
hw/rtl/advisory_file_lock_table.sv
sim/tb.sv
